// ----- rtl/core/rpm_pkg.sv -----
// Shared widths, codes and register map of the resampled preview mixer.
package rpm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int RENDER_W   = 18;
   localparam int OUT_W      = 16;
   localparam int RATE_W     = 21;
   localparam int PHASE_W    = 16;
   localparam int OP_W       = 2;
   localparam int WHOLE_W    = RATE_W + 1 - PHASE_W;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

   // Register select taken from the word address bit.
   localparam logic CSR_REG_RATE   = 1'b0;
   localparam logic CSR_REG_ENABLE = 1'b1;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 2'd0,
      OP_RENDER  = 2'd1,
      OP_RESTART = 2'd2
   } op_type;

   typedef struct packed {
      logic render;
      logic mixed;
      logic dropped;
   } stage_ctl_type;

endpackage

// ----- rtl/core/rpm_if.sv -----
// Item channels of the resampled preview mixer: request and response.
interface rpm_req_if;
   logic                                valid;
   logic                                ready;
   logic [rpm_pkg::OP_W-1:0]            operation;
   logic signed [rpm_pkg::SAMPLE_W-1:0] source_sample;
   logic signed [rpm_pkg::RENDER_W-1:0] render_left;
   logic signed [rpm_pkg::RENDER_W-1:0] render_right;

   modport source (output valid, operation, source_sample, render_left, render_right,
                   input ready);
   modport sink   (input valid, operation, source_sample, render_left, render_right,
                   output ready);
endinterface

interface rpm_rsp_if #(parameter int LEVEL_W = 9);
   logic                             valid;
   logic                             ready;
   logic signed [rpm_pkg::OUT_W-1:0] left_out;
   logic signed [rpm_pkg::OUT_W-1:0] right_out;
   logic                             preview_mixed;
   logic                             sample_dropped;
   logic [LEVEL_W-1:0]               store_level;

   modport source (output valid, left_out, right_out, preview_mixed, sample_dropped,
                   store_level, input ready);
   modport sink   (input valid, left_out, right_out, preview_mixed, sample_dropped,
                   store_level, output ready);
endinterface

// ----- rtl/core/rpm_mix_lane.sv -----
// One output channel: adds the preview sample, scales by 32767/65536 and saturates.
module rpm_mix_lane (
   input  logic signed [rpm_pkg::RENDER_W-1:0] render,
   input  logic signed [rpm_pkg::SAMPLE_W-1:0] preview,
   output logic signed [rpm_pkg::OUT_W-1:0]    mixed
);
   import rpm_pkg::*;

   logic signed [19:0] acc;
   logic signed [35:0] prod;
   logic signed [35:0] prod_adj;
   logic signed [19:0] quot;
   logic               ovf;

   // Twice the render sample plus the preview sample.
   assign acc = {render[RENDER_W-1], render, 1'b0}
              + {{(20-SAMPLE_W){preview[SAMPLE_W-1]}}, preview};

   // Times 32767 as a shift and a subtract.
   assign prod = {acc[19], acc, 15'b0} - {{16{acc[19]}}, acc};

   // Bias negative values so the arithmetic shift truncates toward zero.
   assign prod_adj = prod + (prod[35] ? 36'sd65535 : 36'sd0);
   assign quot     = prod_adj[35:16];

   // Saturate when the upper bits are not a sign extension.
   assign ovf = (quot[19:OUT_W-1] != {(21-OUT_W){quot[19]}});

   always_comb begin
      if (ovf) begin
         mixed = quot[19] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
         mixed = quot[OUT_W-1:0];
      end
   end

endmodule

// ----- rtl/core/resampled_preview_mixer.sv -----
// Resampled preview mixer: sample store, phase stepping and stereo saturating mix.
// A result passes the store read and first stage registers, then the output register.
// Throughput: one item per cycle while the output is not held; the store has one write port and one read port.
// A push writes the store at its accept edge and a render reads it at its accept edge.
// Reset clears indices, fill count, phase, pipeline valids and the enable register, and sets the rate to RATE_RESET.
// The store contents are not cleared; the fill count guards every read.
module resampled_preview_mixer #(
   parameter int STORE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   rpm_req_if.sink                           req_ch,
   rpm_rsp_if.source                         rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rpm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rpm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [rpm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import rpm_pkg::*;

   localparam int ADDR_W  = $clog2(STORE_DEPTH);
   localparam int LEVEL_W = $clog2(STORE_DEPTH + 1);
   localparam int CMP_W   = (LEVEL_W > WHOLE_W) ? LEVEL_W : WHOLE_W;
   localparam logic [LEVEL_W-1:0] DEPTH_L  = LEVEL_W'(STORE_DEPTH);
   localparam logic [ADDR_W-1:0]  LAST_IDX = ADDR_W'(STORE_DEPTH - 1);
   localparam logic [ADDR_W:0]    DEPTH_X  = (ADDR_W + 1)'(STORE_DEPTH);

   // Configuration registers.
   logic [RATE_W-1:0] rate_ff;
   logic              enable_ff;
   logic              csr_wr;

   // Store control state.
   logic [ADDR_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [LEVEL_W-1:0] fill_ff, fill_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;

   // Sample store.
   logic [SAMPLE_W-1:0] store_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // Pipeline registers.
   logic                       s1_valid_ff;
   stage_ctl_type              s1_ctl_ff, s1_ctl_in;
   logic [LEVEL_W-1:0]         s1_level_ff;
   logic signed [RENDER_W-1:0] s1_left_ff, s1_right_ff;
   logic                       out_valid_ff;
   logic signed [OUT_W-1:0]    out_left_ff, out_right_ff;
   logic                       out_mixed_ff, out_dropped_ff;
   logic [LEVEL_W-1:0]         out_level_ff;

   logic                       accept;
   logic                       advance;
   logic                       mem_we;
   logic [RATE_W:0]            phase_sum;
   logic [WHOLE_W-1:0]         whole;
   logic [LEVEL_W-1:0]         whole_cap;
   logic [ADDR_W:0]            rd_adv;
   logic [ADDR_W-1:0]          rd_wrap;
   logic [ADDR_W-1:0]          wr_next;
   logic signed [SAMPLE_W-1:0] preview;
   logic signed [OUT_W-1:0]    mix_left, mix_right;

   // Register port: writes complete in the access phase, pready tied high.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_RESET;
         enable_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_REG_RATE:   rate_ff   <= csr_pwdata[RATE_W-1:0];
            CSR_REG_ENABLE: enable_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_REG_RATE:   csr_prdata = CSR_DATA_W'(rate_ff);
         CSR_REG_ENABLE: csr_prdata = CSR_DATA_W'(enable_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Handshake: the whole pipeline moves unless the output item is held.
   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   // Phase step and the number of whole samples crossed, capped at the fill.
   assign phase_sum = (RATE_W + 1)'(phase_ff) + (RATE_W + 1)'(rate_ff);
   assign whole     = phase_sum[RATE_W:PHASE_W];
   assign whole_cap = (CMP_W'(whole) > CMP_W'(fill_ff)) ? fill_ff : LEVEL_W'(whole);
   assign rd_adv    = (ADDR_W + 1)'(rd_idx_ff) + (ADDR_W + 1)'(whole_cap);
   assign rd_wrap   = (rd_adv >= DEPTH_X) ? ADDR_W'(rd_adv - DEPTH_X) : ADDR_W'(rd_adv);
   assign wr_next   = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + ADDR_W'(1);

   // Next store state for the accepted item.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      fill_in   = fill_ff;
      phase_in  = phase_ff;
      mem_we    = 1'b0;
      s1_ctl_in = '0;
      if (accept) begin
         case (op_type'(req_ch.operation))
            OP_PUSH: begin
               if (fill_ff == DEPTH_L) begin
                  s1_ctl_in.dropped = 1'b1;
               end else begin
                  mem_we    = 1'b1;
                  wr_idx_in = wr_next;
                  fill_in   = fill_ff + LEVEL_W'(1);
               end
            end
            OP_RENDER: begin
               s1_ctl_in.render = 1'b1;
               if (enable_ff && fill_ff != '0) begin
                  s1_ctl_in.mixed = 1'b1;
                  phase_in        = phase_sum[PHASE_W-1:0];
                  rd_idx_in       = rd_wrap;
                  fill_in         = fill_ff - whole_cap;
               end
            end
            OP_RESTART: begin
               wr_idx_in = '0;
               rd_idx_in = '0;
               fill_in   = '0;
               phase_in  = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
         phase_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
         phase_ff  <= phase_in;
      end
   end

   // Store write on push, registered read of the head entry.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_idx_ff] <= req_ch.source_sample;
      end
      if (advance) begin
         rd_data_ff <= store_mem[rd_idx_ff];
      end
   end

   // First stage: item control and render samples wait for the store data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctl_ff   <= s1_ctl_in;
         s1_level_ff <= fill_in;
         s1_left_ff  <= req_ch.render_left;
         s1_right_ff <= req_ch.render_right;
      end
   end

   // Mix both channels with the head sample when one was taken.
   assign preview = s1_ctl_ff.mixed ? $signed(rd_data_ff) : '0;

   rpm_mix_lane u_mix_left (
      .render  (s1_left_ff),
      .preview (preview),
      .mixed   (mix_left)
   );

   rpm_mix_lane u_mix_right (
      .render  (s1_right_ff),
      .preview (preview),
      .mixed   (mix_right)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_left_ff    <= s1_ctl_ff.render ? mix_left : '0;
         out_right_ff   <= s1_ctl_ff.render ? mix_right : '0;
         out_mixed_ff   <= s1_ctl_ff.mixed;
         out_dropped_ff <= s1_ctl_ff.dropped;
         out_level_ff   <= s1_level_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.left_out       = out_left_ff;
   assign rsp_ch.right_out      = out_right_ff;
   assign rsp_ch.preview_mixed  = out_mixed_ff;
   assign rsp_ch.sample_dropped = out_dropped_ff;
   assign rsp_ch.store_level    = out_level_ff;

   // The fill count never exceeds the store depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= DEPTH_L)
      else $error("fill count above store depth");

   // An empty or full store has its indices aligned.
   a_index_align: assert property (@(posedge clock) disable iff (reset)
      (fill_ff == '0 || fill_ff == DEPTH_L) |-> wr_idx_ff == rd_idx_ff)
      else $error("store indices disagree with fill count");

   // A restart leaves the store empty and the phase at zero.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.operation == OP_RESTART) |=> (fill_ff == '0 && phase_ff == '0))
      else $error("restart did not clear the store state");

   // A stalled first stage keeps its item.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_level_ff)))
      else $error("first stage item lost during stall");

endmodule

// ----- verif/resampled_preview_mixer_test.sv -----
// Self-checking testbench of the resampled preview mixer with a predicting scoreboard.
`timescale 1ns / 100ps

// One result item as the block presents it.
typedef struct {
   logic signed [rpm_pkg::OUT_W-1:0] left;
   logic signed [rpm_pkg::OUT_W-1:0] right;
   logic                             mixed;
   logic                             dropped;
   logic [8:0]                       level;
} mix_result_type;

// Predicts every result from the accepted items and compares the block against it.
class mix_scoreboard;
   localparam int DEPTH      = 256;
   localparam int OUT_MAX    = 32767;
   localparam int OUT_MIN    = -32768;
   localparam int MIX_GAIN   = 32767;
   localparam int MAX_REPORT = 10;

   logic [rpm_pkg::SAMPLE_W-1:0] samples [DEPTH];
   logic [7:0]                   wr_ptr;
   logic [7:0]                   rd_ptr;
   logic [8:0]                   held;
   logic [rpm_pkg::PHASE_W-1:0]  phase;
   logic [rpm_pkg::RATE_W-1:0]   ratio;
   logic                         mix_on;
   mix_result_type               expected_out [$];
   int                           failures;

   function new();
      wr_ptr   = '0;
      rd_ptr   = '0;
      held     = '0;
      phase    = '0;
      ratio    = rpm_pkg::RATE_RESET;
      mix_on   = 1'b0;
      failures = 0;
   endfunction

   function void write_register(logic [rpm_pkg::CSR_ADDR_W-1:0] addr,
                                logic [rpm_pkg::CSR_DATA_W-1:0] data);
      if (addr[2] == rpm_pkg::CSR_REG_RATE)
         ratio = data[rpm_pkg::RATE_W-1:0];
      else
         mix_on = data[0];
   endfunction

   // (2r + s) * 32767 / 65536, truncated toward zero and clamped to 16 bits.
   function logic signed [rpm_pkg::OUT_W-1:0] scale_and_clamp(
         logic signed [rpm_pkg::RENDER_W-1:0] r, logic signed [rpm_pkg::SAMPLE_W-1:0] s);
      longint prod;
      longint q;
      prod = (2 * longint'(r) + longint'(s)) * MIX_GAIN;
      if (prod < 0)
         q = -((-prod) >>> 16);
      else
         q = prod >>> 16;
      if (q > longint'(OUT_MAX)) q = longint'(OUT_MAX);
      if (q < longint'(OUT_MIN)) q = longint'(OUT_MIN);
      return q[rpm_pkg::OUT_W-1:0];
   endfunction

   // Advances the predicted state by one accepted item and queues its result.
   function void note_item(logic [rpm_pkg::OP_W-1:0] op,
                           logic signed [rpm_pkg::SAMPLE_W-1:0] smp,
                           logic signed [rpm_pkg::RENDER_W-1:0] lft,
                           logic signed [rpm_pkg::RENDER_W-1:0] rgt);
      mix_result_type                exp;
      logic signed [rpm_pkg::SAMPLE_W-1:0] head;
      logic [21:0]                   sum;
      logic [8:0]                    whole;
      exp.left    = '0;
      exp.right   = '0;
      exp.mixed   = 1'b0;
      exp.dropped = 1'b0;
      head        = '0;
      case (op)
         rpm_pkg::OP_PUSH: begin
            if (held == DEPTH) begin
               exp.dropped = 1'b1;
            end else begin
               samples[wr_ptr] = smp;
               wr_ptr = wr_ptr + 8'd1;
               held   = held + 9'd1;
            end
         end
         rpm_pkg::OP_RENDER: begin
            if (mix_on && held != 0) begin
               head      = samples[rd_ptr];
               exp.mixed = 1'b1;
               sum       = 22'(phase) + 22'(ratio);
               whole     = 9'(sum[21:16]);
               phase     = sum[15:0];
               // Never step past what the store holds.
               if (whole > held) whole = held;
               rd_ptr = rd_ptr + whole[7:0];
               held   = held - whole;
            end
            exp.left  = scale_and_clamp(lft, head);
            exp.right = scale_and_clamp(rgt, head);
         end
         rpm_pkg::OP_RESTART: begin
            wr_ptr = '0;
            rd_ptr = '0;
            held   = '0;
            phase  = '0;
         end
         default: begin
         end
      endcase
      exp.level = held;
      expected_out.push_back(exp);
   endfunction

   // Compares one result item with the oldest prediction.
   function void check_result(mix_result_type act);
      mix_result_type exp;
      if (expected_out.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORT)
            $display("%0t: result item with no prediction pending", $time);
         return;
      end
      exp = expected_out.pop_front();
      if (act.left !== exp.left || act.right !== exp.right || act.mixed !== exp.mixed ||
          act.dropped !== exp.dropped || act.level !== exp.level) begin
         failures++;
         if (failures <= MAX_REPORT)
            $display({"%0t: mismatch exp/act left %0d/%0d right %0d/%0d",
                      " mixed %b/%b dropped %b/%b level %0d/%0d"},
                     $time, exp.left, act.left, exp.right, act.right, exp.mixed, act.mixed,
                     exp.dropped, act.dropped, exp.level, act.level);
      end
   endfunction
endclass

module resampled_preview_mixer_test;
   import rpm_pkg::*;

   localparam logic [OP_W-1:0]       OP_UNUSED   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] RATE_ADDR   = {CSR_REG_RATE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = {CSR_REG_ENABLE, 2'b00};
   localparam int RATE_MAX     = 1048576;
   localparam int SETTLE       = 6;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_AT      = 300;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_ITEMS  = 205;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   rpm_req_if             req_if ();
   rpm_rsp_if #(.LEVEL_W(9)) rsp_if ();

   mix_scoreboard sb;
   int            items_accepted = 0;
   int            cycle_count = 0;
   bit            steady_sender = 1'b0;
   logic [RATE_W-1:0] phase_rate [PHASE_COUNT];
   logic              phase_enable [PHASE_COUNT];

   resampled_preview_mixer #(.STORE_DEPTH(256)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [RENDER_W-1:0] pick_render();
      case ($urandom_range(0, 11))
         0: return 18'sh1FFFF;
         1: return 18'sh20000;
         2: return '0;
         default: return RENDER_W'($urandom);
      endcase
   endfunction

   // Offers one item and returns at the edge that accepts it, plus any idle gap.
   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [SAMPLE_W-1:0] smp,
                            input logic signed [RENDER_W-1:0] lft,
                            input logic signed [RENDER_W-1:0] rgt);
      int gap;
      req_if.valid         <= 1'b1;
      req_if.operation     <= op;
      req_if.source_sample <= smp;
      req_if.render_left   <= lft;
      req_if.render_right  <= rgt;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_item(op, smp, lft, rgt);
      if (op != OP_UNUSED) items_accepted++;
      gap = steady_sender ? 0 : idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random(input logic [OP_W-1:0] op);
      send_item(op, pick_sample(), pick_render(), pick_render());
   endtask

   // Stops offering items and waits until every predicted result has come back.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_out.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_register(addr, data);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Random sequences: push bursts, render bursts, mixed runs, restarts and noise.
   task automatic random_phase(input int count);
      int stop_at;
      int choice;
      int n;
      stop_at = items_accepted + count;
      while (items_accepted < stop_at) begin
         choice        = $urandom_range(0, 99);
         steady_sender = ($urandom_range(0, 3) == 0);
         if (choice < 40) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 270) : $urandom_range(1, 24);
            repeat (n) send_random(OP_PUSH);
         end else if (choice < 85) begin
            n = $urandom_range(1, 40);
            repeat (n) send_random(OP_RENDER);
         end else if (choice < 93) begin
            n = $urandom_range(1, 30);
            repeat (n) send_random($urandom_range(0, 1) ? OP_PUSH : OP_RENDER);
         end else if (choice < 97) begin
            send_random(OP_RESTART);
         end else begin
            send_random(OP_UNUSED);
         end
      end
      steady_sender = 1'b0;
   endtask

   // Every result item is checked at the edge that accepts it.
   always @(posedge clock) begin
      mix_result_type act;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         act.left    = rsp_if.left_out;
         act.right   = rsp_if.right_out;
         act.mixed   = rsp_if.preview_mixed;
         act.dropped = rsp_if.sample_dropped;
         act.level   = rsp_if.store_level;
         sb.check_result(act);
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver: random ready pattern, and one long hold-off while the sender keeps going.
   initial begin
      bit held_once;
      int gap;
      held_once = 1'b0;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!held_once && items_accepted >= HOLD_AT) begin
            held_once = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6))
            @(posedge clock);
         gap = idle_len();
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      sb = new();
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.operation     <= OP_PUSH;
      req_if.source_sample <= '0;
      req_if.render_left   <= '0;
      req_if.render_right  <= '0;
      csr_psel             <= 1'b0;
      csr_penable          <= 1'b0;
      csr_pwrite           <= 1'b0;
      csr_paddr            <= '0;
      csr_pwdata           <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Preview off after reset: frames pass through, pushes still fill the store.
      send_item(OP_RENDER, '0, 18'sh1FFFF, 18'sh20000);
      send_item(OP_RENDER, '0, -18'sd1, 18'sd1);
      send_item(OP_PUSH, 16'sh7FFF, '0, '0);
      send_item(OP_PUSH, 16'sh8000, '0, '0);
      send_item(OP_RENDER, '0, 18'sd100, -18'sd100);
      send_item(OP_UNUSED, pick_sample(), pick_render(), pick_render());
      drain();

      // Preview on at unity rate: mix both extremes, then an empty store.
      csr_write(ENABLE_ADDR, 32'd1);
      send_item(OP_RENDER, '0, 18'sh20000, 18'sh1FFFF);
      send_item(OP_RENDER, '0, '0, '0);
      send_item(OP_RENDER, '0, 18'sd5, -18'sd5);
      drain();

      // Zero rate: the head sample repeats.
      csr_write(RATE_ADDR, 32'd0);
      send_random(OP_PUSH);
      send_random(OP_PUSH);
      repeat (3) send_random(OP_RENDER);
      drain();

      // Largest rate: the step runs past the fill and empties the store.
      csr_write(RATE_ADDR, RATE_MAX);
      send_random(OP_RENDER);
      repeat (3) send_random(OP_PUSH);
      send_random(OP_RENDER);
      send_random(OP_PUSH);
      send_random(OP_RESTART);
      send_random(OP_RENDER);
      send_random(OP_PUSH);
      send_random(OP_RENDER);
      drain();

      // Random phases over a spread of settings.
      phase_rate[0] = 21'd65536;  phase_enable[0] = 1'b1;
      phase_rate[1] = 21'd32768;  phase_enable[1] = 1'b1;
      phase_rate[2] = 21'd98304;  phase_enable[2] = 1'b1;
      phase_rate[3] = 21'd1;      phase_enable[3] = 1'b1;
      phase_rate[4] = 21'(RATE_MAX); phase_enable[4] = 1'b1;
      phase_rate[5] = 21'd0;      phase_enable[5] = 1'b1;
      phase_rate[6] = 21'($urandom_range(1, RATE_MAX)); phase_enable[6] = 1'b0;
      phase_rate[7] = 21'($urandom_range(1, RATE_MAX)); phase_enable[7] = 1'b1;
      for (int p = 0; p < PHASE_COUNT; p++) begin
         csr_write(RATE_ADDR, 32'(phase_rate[p]));
         csr_write(ENABLE_ADDR, 32'(phase_enable[p]));
         random_phase(PHASE_ITEMS);
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (sb.expected_out.size() != 0) sb.failures++;
      if (sb.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/rpm_pkg.sv
rtl/core/rpm_if.sv
rtl/core/rpm_mix_lane.sv
rtl/core/resampled_preview_mixer.sv
verif/resampled_preview_mixer_test.sv
